@@ rtl/sfp_pkg.sv @@
// Shared types and constants of the short file name parser.
package sfp_pkg;

   localparam int BASE_CHARS  = 8;
   localparam int TOTAL_CHARS = 11;
   localparam int STORE_DEPTH = 11;
   localparam int POS_W       = 4;

   localparam logic [7:0] PAD_BYTE   = 8'h20;
   localparam logic [7:0] SLASH_BYTE = 8'h2F;

   localparam logic [1:0] CASE_UNKNOWN = 2'd0;
   localparam logic [1:0] CASE_UPPER   = 2'd1;
   localparam logic [1:0] CASE_LOWER   = 2'd2;

   localparam logic CSR_FLAGS_EN  = 1'b0;
   localparam logic CSR_LONG_NAME = 1'b1;

   typedef struct packed {
      logic flags_en;
      logic long_mode;
   } cfg_type;

   typedef struct packed {
      logic [STORE_DEPTH-1:0][7:0] store;
      logic [POS_W-1:0]            wpos;
      logic                        in_ext;
      logic [1:0]                  base_seen;
      logic [1:0]                  ext_seen;
      logic [1:0]                  lower_found;
      logic [1:0]                  lower_allowed;
      logic                        skipping;
   } seg_state_type;

   typedef struct packed {
      logic        status;
      logic [63:0] base_bytes;
      logic [23:0] ext_bytes;
      logic [1:0]  case_flags;
      logic        ended_by_slash;
   } result_type;

   localparam seg_state_type SEG_CLEAR = '{
      store:         {STORE_DEPTH{PAD_BYTE}},
      wpos:          '0,
      in_ext:        1'b0,
      base_seen:     CASE_UNKNOWN,
      ext_seen:      CASE_UNKNOWN,
      lower_found:   2'b00,
      lower_allowed: 2'b11,
      skipping:      1'b0
   };

endpackage

@@ rtl/short_filename_parser_top.sv @@
// Top level of the short file name parser: stream ports, registers and control.
// The parser takes one path byte per cycle and, when a non-empty segment ends or an error
// is found, returns one word holding the space-padded 8.3 name, its lower-case flags and
// the kind of terminator. Each byte passes through an input register and, when it
// produces a word, a result register before the word is offered; bytes keep flowing at
// one per cycle as long as the result side takes words when offered. Configuration
// writes take effect on the next byte.
module short_filename_parser_top import sfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // path_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // base_bytes, ext_bytes, case_flags, zero fill
   output logic [1:0]  rsp_tuser,   // status, ended_by_slash
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic        csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   seg_state_type seg_ff, seg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_res_ff, rsp_res_in;

   seg_state_type step_nxt;
   logic          step_emit;
   result_type    step_res;
   logic          advance;
   logic          req_take;

   sfp_step u_step (
      .st        (seg_ff),
      .path_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .nxt       (step_nxt),
      .emit      (step_emit),
      .res       (step_res)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FLAGS_EN:  cfg_in.flags_en  = csr_wdata;
            CSR_LONG_NAME: cfg_in.long_mode = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign in_byte_in   = req_take ? req_tdata : in_byte_ff;
   assign seg_in       = advance ? step_nxt : seg_ff;
   assign rsp_valid_in = advance ? step_emit : (rsp_valid_ff && !rsp_tready);
   assign rsp_res_in   = (advance && step_emit) ? step_res : rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         seg_ff       <= SEG_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_res_ff.case_flags, rsp_res_ff.ext_bytes,
                        rsp_res_ff.base_bytes};
   assign rsp_tuser  = {rsp_res_ff.ended_by_slash, rsp_res_ff.status};

endmodule

@@ rtl/sfp_step.sv @@
// Per-byte next-state and result logic of the short file name parser.
module sfp_step import sfp_pkg::*; (
   input  seg_state_type st,
   input  logic [7:0]    path_byte,
   input  cfg_type       cfg,
   output seg_state_type nxt,
   output logic          emit,
   output result_type    res
);

   logic             term;
   logic             printable;
   logic             is_up;
   logic             is_lo;
   logic             dot;
   logic             forb;
   logic [7:0]       ch;
   logic [1:0]       part_bit;
   logic [1:0]       seen;
   logic [1:0]       kind;
   logic             mixed;
   logic             case_err;
   logic [POS_W-1:0] limit;
   logic             over;

   function automatic logic is_forbidden(input logic [7:0] b);
      is_forbidden = (b == 8'h22) || (b >= 8'h2A && b <= 8'h2C) || (b == 8'h2E) ||
                     (b == SLASH_BYTE) || (b >= 8'h3A && b <= 8'h3F) ||
                     (b >= 8'h5B && b <= 8'h5D) || (b == 8'h7C);
   endfunction

   assign term      = (path_byte == 8'h00) || (path_byte == SLASH_BYTE);
   assign printable = (path_byte >= 8'h21) && (path_byte <= 8'h7E);
   assign is_up     = (path_byte >= 8'h41) && (path_byte <= 8'h5A);
   assign is_lo     = (path_byte >= 8'h61) && (path_byte <= 8'h7A);
   assign dot       = (path_byte == 8'h2E);
   assign forb      = is_forbidden(path_byte);
   assign ch        = is_lo ? (path_byte - 8'h20) : path_byte;
   assign part_bit  = st.in_ext ? 2'b10 : 2'b01;
   assign seen      = st.in_ext ? st.ext_seen : st.base_seen;
   assign kind      = is_up ? CASE_UPPER : CASE_LOWER;
   assign mixed     = cfg.long_mode && (seen != CASE_UNKNOWN) && (seen != kind);
   assign case_err  = (is_lo && cfg.long_mode && !cfg.flags_en) ||
                      (cfg.flags_en && (is_up || is_lo) && mixed);
   assign limit     = st.in_ext ? POS_W'(TOTAL_CHARS) : POS_W'(BASE_CHARS);
   assign over      = (st.wpos >= limit);

   always_comb begin
      nxt  = st;
      emit = 1'b0;
      res  = '0;
      priority if (st.skipping) begin
         if (term) begin
            nxt.skipping = 1'b0;
         end
      end else if (term && (st.wpos != '0)) begin
         emit = 1'b1;
         for (int i = 0; i < 8; i++) begin
            res.base_bytes[8*(7-i) +: 8] = st.store[i];
         end
         for (int i = 0; i < 3; i++) begin
            res.ext_bytes[8*(2-i) +: 8] = st.store[8+i];
         end
         res.case_flags     = cfg.flags_en ? (st.lower_found & st.lower_allowed) : 2'b00;
         res.ended_by_slash = (path_byte == SLASH_BYTE);
         nxt = SEG_CLEAR;
      end else if (printable && dot && !st.in_ext) begin
         nxt.wpos   = POS_W'(BASE_CHARS);
         nxt.in_ext = 1'b1;
      end else if (!printable || forb || case_err || over) begin
         emit         = 1'b1;
         res.status   = 1'b1;
         nxt          = SEG_CLEAR;
         nxt.skipping = !term;
      end else begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            if (st.wpos == POS_W'(i)) begin
               nxt.store[i] = ch;
            end
         end
         nxt.wpos = st.wpos + POS_W'(1);
         if (cfg.flags_en && (is_up || is_lo)) begin
            if (cfg.long_mode) begin
               if (st.in_ext) begin
                  nxt.ext_seen = kind;
               end else begin
                  nxt.base_seen = kind;
               end
            end
            if (is_up) begin
               nxt.lower_allowed = st.lower_allowed & ~part_bit;
            end else begin
               nxt.lower_found = st.lower_found | part_bit;
            end
         end
      end
   end

endmodule

@@ rtl/sfp_checker.sv @@
// Port-level assertions of the short file name parser and their binding.
module sfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> ((rsp_tdata == '0) && !rsp_tuser[1]))
      else $error("error word carries a nonzero payload");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

   a_base_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0] && rsp_tdata[88]) |-> (rsp_tdata[63:56] != 8'h20))
      else $error("base lower-case flag set on an empty base");

   a_ext_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0] && rsp_tdata[89]) |-> (rsp_tdata[87:80] != 8'h20))
      else $error("extension lower-case flag set on an empty extension");

endmodule

bind short_filename_parser_top sfp_checker u_sfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
